>>> rtl/core/itfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfn_pkg
// Shared types, sizes and conversion functions for the indexed triangle
// flat-normal unit.
// ----------------------------------------------------------------------------
package itfn_pkg;

    localparam int VERTEX_SLOTS = 256;
    localparam int COORD_BITS   = 16;
    localparam int NORMAL_BITS  = 2 * COORD_BITS + 3;
    localparam int ADDR_W       = $clog2(VERTEX_SLOTS);

    // port field widths
    localparam int IDX_W        = 8;
    localparam int POS_W        = 16;
    localparam int NORM_W       = 35;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 160;
    localparam int OUT_FIELDS_W = 3 * POS_W + 3 * NORM_W;

    localparam int QUEUE_DEPTH  = 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_INDEX = 1'b1;

    typedef logic signed [COORD_BITS-1:0]  coord_t;
    typedef logic signed [COORD_BITS:0]    diff_t;
    typedef logic signed [2*COORD_BITS+1:0] prod_t;
    typedef logic signed [NORMAL_BITS-1:0] norm_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } point_t;

    typedef struct packed {
        diff_t z;
        diff_t y;
        diff_t x;
    } diff3_t;

    // closed triangle or partial-list error, as it leaves the corner stage
    typedef struct packed {
        logic   err;
        point_t p0;
        point_t p1;
        point_t p2;
    } face_t;

    typedef struct packed {
        logic   err;
        point_t p0;
        point_t p1;
        point_t p2;
        norm_t  nz;
        norm_t  ny;
        norm_t  nx;
    } packet_t;

    // low COORD_BITS of the raw field, zero filled above the field
    function automatic coord_t coord_from_field(input logic [POS_W-1:0] raw);
        coord_t r;
        for (int i = 0; i < COORD_BITS; i++) begin
            r[i] = (i < POS_W) ? raw[i] : 1'b0;
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] coord_to_field(input coord_t c);
        logic [POS_W-1:0] r;
        for (int i = 0; i < POS_W; i++) begin
            r[i] = (i < COORD_BITS) ? c[i] : c[COORD_BITS-1];
        end
        return r;
    endfunction

    function automatic logic [NORM_W-1:0] norm_to_field(input norm_t n);
        logic [NORM_W-1:0] r;
        for (int i = 0; i < NORM_W; i++) begin
            r[i] = (i < NORMAL_BITS) ? n[i] : n[NORMAL_BITS-1];
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] a;
        for (int i = 0; i < ADDR_W; i++) begin
            a[i] = (i < IDX_W) ? idx[i] : 1'b0;
        end
        return a;
    endfunction

    function automatic logic slot_in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(VERTEX_SLOTS);
    endfunction

endpackage

>>> rtl/core/indexed_triangle_flat_normals_unit.sv
`timescale 1ns / 1ps
// Throughput: one input transaction per cycle unless a face waits on a full
// queue; each triangle yields three output transactions, back to back while
// m_tready is high, so an index stream keeps pace. Path: the third index of a
// triangle reaches its first corner via vertex RAM read, corner stage, multiply, queue.
// Reset: asynchronous, clears corner count and pipeline/queue occupancy;
// the vertex table is not cleared and holds nothing until written.
// ----------------------------------------------------------------------------
// indexed_triangle_flat_normals_unit
// Vertex table with indexed fetch, triangle assembly and flat face normals.
// ----------------------------------------------------------------------------
module indexed_triangle_flat_normals_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vertex_index, pos_x, pos_y, pos_z
    input  logic [itfn_pkg::IN_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_x, out_y, out_z, normal_x, normal_y, normal_z, zero pad
    output logic [itfn_pkg::OUT_TDATA_W-1:0] m_tdata,
    // partial_error
    output logic                              m_tuser,
    output logic                              m_tlast
);

    logic [itfn_pkg::IDX_W-1:0]  vertex_index;
    itfn_pkg::point_t            load_pt;
    logic                        accept;
    logic                        adv;
    logic                        we;
    itfn_pkg::point_t            rd_data;

    logic                        s1_valid_reg;
    logic                        s1_hit_reg;
    logic                        s1_eol_reg;

    logic                        s2_valid;
    itfn_pkg::face_t             s2_face;
    itfn_pkg::diff3_t            s2_u;
    itfn_pkg::diff3_t            s2_v;
    logic                        s3_valid;
    itfn_pkg::packet_t           s3_pkt;
    logic                        q_full;

    assign vertex_index = s_tdata[7:0];
    assign load_pt.x    = itfn_pkg::coord_from_field(s_tdata[23:8]);
    assign load_pt.y    = itfn_pkg::coord_from_field(s_tdata[39:24]);
    assign load_pt.z    = itfn_pkg::coord_from_field(s_tdata[55:40]);

    // whole pipeline moves together; it only holds when a face waits on a full queue
    assign adv      = !(s3_valid && q_full);
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;
    assign we       = accept && s_tuser == itfn_pkg::CMD_LOAD
                      && itfn_pkg::slot_in_range(vertex_index);

    itfn_ram #(
        .WIDTH ($bits(itfn_pkg::point_t)),
        .DEPTH (itfn_pkg::VERTEX_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (itfn_pkg::slot_addr(vertex_index)),
        .wdata (load_pt),
        .re    (adv),
        .raddr (itfn_pkg::slot_addr(vertex_index)),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept && s_tuser == itfn_pkg::CMD_INDEX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_hit_reg <= itfn_pkg::slot_in_range(vertex_index);
            s1_eol_reg <= s_tlast;
        end
    end

    itfn_corner u_corner (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s1_valid_reg),
        .in_hit    (s1_hit_reg),
        .in_eol    (s1_eol_reg),
        .rd_data   (rd_data),
        .out_valid (s2_valid),
        .out_face  (s2_face),
        .out_u     (s2_u),
        .out_v     (s2_v)
    );

    itfn_normal u_normal (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s2_valid),
        .in_face   (s2_face),
        .in_u      (s2_u),
        .in_v      (s2_v),
        .out_valid (s3_valid),
        .out_pkt   (s3_pkt)
    );

    itfn_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s3_valid && adv),
        .push_pkt (s3_pkt),
        .full     (q_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_load_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == itfn_pkg::CMD_LOAD) |=> !s1_valid_reg)
        else $error("load transaction entered the index pipeline");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && s3_valid) |=> s3_valid)
        else $error("face dropped while the pipeline was held");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input held while no result is pending");

endmodule

>>> rtl/core/itfn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfn_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module itfn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/itfn_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfn_corner
// Keeps the open triangle's corners, closes each third index into a face
// and forms the edge vectors; flags a list ending on a partial triangle.
// ----------------------------------------------------------------------------
module itfn_corner (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  logic                   in_hit,
    input  logic                   in_eol,
    input  itfn_pkg::point_t       rd_data,
    output logic                   out_valid,
    output itfn_pkg::face_t        out_face,
    output itfn_pkg::diff3_t       out_u,
    output itfn_pkg::diff3_t       out_v
);

    localparam logic [1:0] CNT_ZERO = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    logic [1:0]        count_reg, count_next;
    itfn_pkg::point_t  first_reg, first_next;
    itfn_pkg::point_t  second_reg, second_next;
    logic              valid_reg, valid_next;
    itfn_pkg::face_t   face_reg, face_next;
    itfn_pkg::diff3_t  u_reg, u_next;
    itfn_pkg::diff3_t  v_reg, v_next;
    itfn_pkg::point_t  p;

    always_comb
    begin
        // slot beyond the table reads as the origin
        p           = in_hit ? rd_data : '0;
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        valid_next  = valid_reg;
        face_next   = face_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        if (adv)
        begin
            valid_next = 1'b0;
            if (in_valid)
            begin
                case (count_reg)
                    CNT_TWO:
                    begin
                        valid_next   = 1'b1;
                        face_next.err = 1'b0;
                        face_next.p0 = first_reg;
                        face_next.p1 = second_reg;
                        face_next.p2 = p;
                        u_next.x = itfn_pkg::diff_t'(second_reg.x) - itfn_pkg::diff_t'(first_reg.x);
                        u_next.y = itfn_pkg::diff_t'(second_reg.y) - itfn_pkg::diff_t'(first_reg.y);
                        u_next.z = itfn_pkg::diff_t'(second_reg.z) - itfn_pkg::diff_t'(first_reg.z);
                        v_next.x = itfn_pkg::diff_t'(p.x) - itfn_pkg::diff_t'(first_reg.x);
                        v_next.y = itfn_pkg::diff_t'(p.y) - itfn_pkg::diff_t'(first_reg.y);
                        v_next.z = itfn_pkg::diff_t'(p.z) - itfn_pkg::diff_t'(first_reg.z);
                        count_next = CNT_ZERO;
                    end
                    CNT_ONE:
                    begin
                        second_next = p;
                        count_next  = CNT_TWO;
                    end
                    default:
                    begin
                        first_next = p;
                        count_next = CNT_ONE;
                    end
                endcase
                // end mark on an open triangle: zeroed error transaction
                if (in_eol && count_reg != CNT_TWO)
                begin
                    valid_next    = 1'b1;
                    face_next     = '0;
                    face_next.err = 1'b1;
                    u_next        = '0;
                    v_next        = '0;
                    count_next    = CNT_ZERO;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_ZERO;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
        face_reg   <= face_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
    end

    assign out_valid = valid_reg;
    assign out_face  = face_reg;
    assign out_u     = u_reg;
    assign out_v     = v_reg;

endmodule

>>> rtl/core/itfn_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfn_normal
// Cross product stage: six registered partial products, then the three
// differences that give the unnormalised face normal.
// ----------------------------------------------------------------------------
module itfn_normal (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  itfn_pkg::face_t        in_face,
    input  itfn_pkg::diff3_t       in_u,
    input  itfn_pkg::diff3_t       in_v,
    output logic                   out_valid,
    output itfn_pkg::packet_t      out_pkt
);

    logic              valid_reg;
    itfn_pkg::face_t   face_reg;
    itfn_pkg::prod_t   prod_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            face_reg    <= in_face;
            prod_reg[0] <= itfn_pkg::prod_t'(in_u.y) * itfn_pkg::prod_t'(in_v.z);
            prod_reg[1] <= itfn_pkg::prod_t'(in_u.z) * itfn_pkg::prod_t'(in_v.y);
            prod_reg[2] <= itfn_pkg::prod_t'(in_u.z) * itfn_pkg::prod_t'(in_v.x);
            prod_reg[3] <= itfn_pkg::prod_t'(in_u.x) * itfn_pkg::prod_t'(in_v.z);
            prod_reg[4] <= itfn_pkg::prod_t'(in_u.x) * itfn_pkg::prod_t'(in_v.y);
            prod_reg[5] <= itfn_pkg::prod_t'(in_u.y) * itfn_pkg::prod_t'(in_v.x);
        end
    end

    always_comb
    begin
        out_pkt.err = face_reg.err;
        out_pkt.p0  = face_reg.p0;
        out_pkt.p1  = face_reg.p1;
        out_pkt.p2  = face_reg.p2;
        out_pkt.nx  = itfn_pkg::norm_t'(prod_reg[0]) - itfn_pkg::norm_t'(prod_reg[1]);
        out_pkt.ny  = itfn_pkg::norm_t'(prod_reg[2]) - itfn_pkg::norm_t'(prod_reg[3]);
        out_pkt.nz  = itfn_pkg::norm_t'(prod_reg[4]) - itfn_pkg::norm_t'(prod_reg[5]);
    end

    assign out_valid = valid_reg;

endmodule

>>> rtl/core/itfn_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itfn_outq
// Two-entry face queue and serialiser: three corner transactions per face,
// one transaction per error entry.
// ----------------------------------------------------------------------------
module itfn_outq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  itfn_pkg::packet_t                 push_pkt,
    output logic                              full,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_x, out_y, out_z, normal_x, normal_y, normal_z, zero pad
    output logic [itfn_pkg::OUT_TDATA_W-1:0] m_tdata,
    // partial_error
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam logic [1:0] SUB_LAST = 2'd2;

    itfn_pkg::packet_t q_reg [itfn_pkg::QUEUE_DEPTH];
    logic [1:0]        count_reg, count_next;
    logic              head_reg, tail_reg;
    logic [1:0]        sub_reg, sub_next;
    itfn_pkg::packet_t head;
    itfn_pkg::point_t  corner;
    logic              fire;
    logic              pop;

    assign head     = q_reg[head_reg];
    assign m_tvalid = count_reg != 2'd0;
    assign full     = count_reg == 2'(itfn_pkg::QUEUE_DEPTH);
    assign fire     = m_tvalid && m_tready;
    assign m_tlast  = head.err || sub_reg == SUB_LAST;
    assign m_tuser  = head.err;
    assign pop      = fire && m_tlast;

    always_comb
    begin
        case (sub_reg)
            2'd0:    corner = head.p0;
            2'd1:    corner = head.p1;
            default: corner = head.p2;
        endcase
        if (head.err)
        begin
            m_tdata = '0;
        end
        else
        begin
            m_tdata = {
                (itfn_pkg::OUT_TDATA_W - itfn_pkg::OUT_FIELDS_W)'(0),
                itfn_pkg::norm_to_field(head.nz),
                itfn_pkg::norm_to_field(head.ny),
                itfn_pkg::norm_to_field(head.nx),
                itfn_pkg::coord_to_field(corner.z),
                itfn_pkg::coord_to_field(corner.y),
                itfn_pkg::coord_to_field(corner.x)
            };
        end
    end

    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
        sub_next   = sub_reg;
        if (fire)
        begin
            sub_next = pop ? 2'd0 : sub_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            sub_reg   <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            sub_reg   <= sub_next;
            if (push)
            begin
                tail_reg <= ~tail_reg;
            end
            if (pop)
            begin
                head_reg <= ~head_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[tail_reg] <= push_pkt;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("face pushed into a full queue");

    a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("error transaction not zeroed or not last");

    a_sub_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> sub_reg == 2'd0)
        else $error("corner index not restarted after face");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue occupancy out of range");

endmodule
